[sv/nibble_sbox_feistel_cipher_top_assert.svh]
// Assertion macros used by the cipher top
`ifndef NIBBLE_SBOX_FEISTEL_CIPHER_TOP_ASSERT_SVH
`define NIBBLE_SBOX_FEISTEL_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define NSFC_ASSERT_IMPL(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define NSFC_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/nsfc_pkg.sv]
package nsfc_pkg;

	localparam int WORD_W    = 32;
	localparam int HALF_W    = 16;
	localparam int NIB_W     = 4;
	localparam int SEED_RNDS = 16;
	localparam int PAY_RNDS  = 4;
	localparam int CELLS     = SEED_RNDS;
	localparam int SEED_IW   = $clog2(SEED_RNDS);
	localparam int PAY_IW    = $clog2(PAY_RNDS);

	// cipher modes
	typedef enum logic {
		MODE_SEED = 1'b0,
		MODE_PAY  = 1'b1
	} mode_t;

	// control that travels beside each word through the cell chain
	typedef struct packed {
		logic  valid;
		mode_t mode;
	} ctl_t;

	// 32-entry nibble substitution table
	function automatic logic [NIB_W-1:0] nib_box(input logic [4:0] idx);
		logic [NIB_W-1:0] v;
		case (idx)
			5'd0:  v = 4'h5;  5'd1:  v = 4'h6;  5'd2:  v = 4'h7;  5'd3:  v = 4'h1;
			5'd4:  v = 4'h9;  5'd5:  v = 4'hC;  5'd6:  v = 4'hD;  5'd7:  v = 4'h8;
			5'd8:  v = 4'hA;  5'd9:  v = 4'hD;  5'd10: v = 4'h2;  5'd11: v = 4'hB;
			5'd12: v = 4'hF;  5'd13: v = 4'h4;  5'd14: v = 4'h0;  5'd15: v = 4'h3;
			5'd16: v = 4'hB;  5'd17: v = 4'h4;  5'd18: v = 4'h6;  5'd19: v = 4'h0;
			5'd20: v = 4'hF;  5'd21: v = 4'h2;  5'd22: v = 4'hD;  5'd23: v = 4'h9;
			5'd24: v = 4'h5;  5'd25: v = 4'hC;  5'd26: v = 4'h1;  5'd27: v = 4'hA;
			5'd28: v = 4'h3;  5'd29: v = 4'hD;  5'd30: v = 4'hE;  5'd31: v = 4'h8;
			default: v = 4'h0;
		endcase
		return v;
	endfunction

	// seed-to-key round keys, table order
	function automatic logic [HALF_W-1:0] seed_key(input logic [SEED_IW-1:0] idx);
		logic [HALF_W-1:0] k;
		case (idx)
			4'd0:  k = 16'h53DA;  4'd1:  k = 16'h33BC;  4'd2:  k = 16'h72EB;
			4'd3:  k = 16'h437D;  4'd4:  k = 16'h7CA3;  4'd5:  k = 16'h3382;
			4'd6:  k = 16'h834F;  4'd7:  k = 16'h3608;  4'd8:  k = 16'hAFB8;
			4'd9:  k = 16'h503D;  4'd10: k = 16'hDBA3;  4'd11: k = 16'h9D34;
			4'd12: k = 16'h3563;  4'd13: k = 16'h6B70;  4'd14: k = 16'h6E74;
			4'd15: k = 16'h88F0;
			default: k = 16'h0000;
		endcase
		return k;
	endfunction

	// payload round keys, table order
	function automatic logic [HALF_W-1:0] pay_key(input logic [PAY_IW-1:0] idx);
		logic [HALF_W-1:0] k;
		case (idx)
			2'd0: k = 16'h7856;
			2'd1: k = 16'hCE22;
			2'd2: k = 16'hF513;
			2'd3: k = 16'h6E86;
			default: k = 16'h0000;
		endcase
		return k;
	endfunction

endpackage

[sv/nsfc_cell.sv]
module nsfc_cell
	import nsfc_pkg::*;
#(
	parameter logic [HALF_W-1:0] SEED_KEY = '0,
	parameter logic [HALF_W-1:0] PAY_KEY  = '0,
	parameter bit                PAY_ON   = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_t              ctl_in,
	input  logic [WORD_W-1:0] data_in,
	output ctl_t              ctl_out,
	output logic [WORD_W-1:0] data_out
);

	logic [HALF_W-1:0] lo;
	logic [HALF_W-1:0] hi;
	logic [HALF_W-1:0] rk;
	logic [HALF_W-1:0] ix;
	logic [WORD_W-1:0] dup;
	logic [HALF_W-1:0] f;
	logic [HALF_W-1:0] f_rot;
	logic [WORD_W-1:0] rnd;
	logic [WORD_W-1:0] nxt;
	ctl_t              ctl_s1;
	logic [WORD_W-1:0] data_s1;

	// one Feistel round
	always_comb begin
		lo  = data_in[HALF_W-1:0];
		hi  = data_in[WORD_W-1:HALF_W];
		rk  = (ctl_in.mode == MODE_PAY) ? PAY_KEY : SEED_KEY;
		ix  = lo ^ rk;
		dup = {ix, ix};
		for (int n = 0; n < HALF_W / NIB_W; n++) begin
			f[n*NIB_W +: NIB_W] = nib_box(dup[n*NIB_W +: 5]);
		end
		f_rot = {f[2:0], f[HALF_W-1:3]};
		rnd   = {lo, f_rot ^ hi};
		// payload mode runs fewer rounds: later cells pass the word on
		if (ctl_in.mode == MODE_PAY && !PAY_ON) begin
			nxt = data_in;
		end else begin
			nxt = rnd;
		end
	end

	// stage register: control is reset, data is not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, mode: MODE_SEED};
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

	assign ctl_out  = ctl_s1;
	assign data_out = data_s1;

endmodule

[sv/nibble_sbox_feistel_cipher_top.sv]
// Each request passes through the 16 round-cell registers, in both modes;
// done is the valid bit held in the last cell's register.
// Throughput: one request per cycle; busy is never raised.
// Rate is set by the chain of 16 round cells, one round per cell per cycle.
// The receiver cannot stall: each result shows for one cycle with done high.
// Reset (arst_n low) empties the chain and sets cipher_mode to seed-to-key.
module nibble_sbox_feistel_cipher_top
	import nsfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [WORD_W-1:0] word_in,
	input  logic              cipher_mode_we,
	input  logic              cipher_mode_wdata,
	output logic              done,
	output logic [WORD_W-1:0] word_out
);

	`include "nibble_sbox_feistel_cipher_top_assert.svh"

	mode_t             cipher_mode_q;
	ctl_t              ctl   [CELLS+1];
	logic [WORD_W-1:0] data  [CELLS+1];

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_mode_q <= MODE_SEED;
		end else if (cipher_mode_we) begin
			cipher_mode_q <= mode_t'(cipher_mode_wdata);
		end
	end

	// requests enter the chain every cycle
	assign busy     = 1'b0;
	assign ctl[0]   = '{valid: start, mode: cipher_mode_q};
	assign data[0]  = word_in;

	// chain of round cells; seed keys run last to first, payload keys first to last
	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		localparam logic [HALF_W-1:0] SK = seed_key(SEED_IW'(CELLS - 1 - k));
		localparam logic [HALF_W-1:0] PK = pay_key(PAY_IW'(k));
		localparam bit                PO = (k < PAY_RNDS);

		nsfc_cell #(
			.SEED_KEY (SK),
			.PAY_KEY  (PK),
			.PAY_ON   (PO)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl[k]),
			.data_in  (data[k]),
			.ctl_out  (ctl[k+1]),
			.data_out (data[k+1])
		);
	end

	// final half swap
	assign done     = ctl[CELLS].valid;
	assign word_out = {data[CELLS][HALF_W-1:0], data[CELLS][WORD_W-1:HALF_W]};

	`NSFC_ASSERT_IMPL(a_done_latency, clk, arst_n, done, $past(start, CELLS),
		"result without a request sixteen cycles earlier")
	`NSFC_ASSERT_NEXT(a_first_cell, clk, arst_n, start,
		ctl[1].valid && ctl[1].mode == $past(cipher_mode_q), "request lost at chain entry")
	`NSFC_ASSERT_NEXT(a_pay_bypass, clk, arst_n, ctl[CELLS-1].valid && ctl[CELLS-1].mode == MODE_PAY,
		data[CELLS] == $past(data[CELLS-1]), "payload word altered past its last round")

endmodule
